// ===== hdl/rbst_pkg.sv =====
// Package: widths, register map and defaults for the ray box-pair slab test.
package rbst_pkg;

  // Default number format (signed fixed point)
  localparam int COORD_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;

  // Fixed field widths on the ports
  localparam int PAIR_W = 64;
  localparam int VAL_W  = 32;

  // Configuration port
  localparam int NUM_REGS = 6;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } rbst_reg_e;

endpackage

// ===== hdl/rbst_in_if.sv =====
// Interface: input channel carrying the box pairs of one node and the hit limit.
interface rbst_in_if;
  logic                         valid;
  logic                         ready;
  logic [rbst_pkg::PAIR_W-1:0]  x_lo_pair;
  logic [rbst_pkg::PAIR_W-1:0]  x_hi_pair;
  logic [rbst_pkg::PAIR_W-1:0]  y_lo_pair;
  logic [rbst_pkg::PAIR_W-1:0]  y_hi_pair;
  logic [rbst_pkg::PAIR_W-1:0]  z_lo_pair;
  logic [rbst_pkg::PAIR_W-1:0]  z_hi_pair;
  logic signed [rbst_pkg::VAL_W-1:0] t_limit;

  modport source (output valid, x_lo_pair, x_hi_pair, y_lo_pair, y_hi_pair,
                  z_lo_pair, z_hi_pair, t_limit, input ready);
  modport sink   (input valid, x_lo_pair, x_hi_pair, y_lo_pair, y_hi_pair,
                  z_lo_pair, z_hi_pair, t_limit, output ready);
endinterface

// ===== hdl/rbst_out_if.sv =====
// Interface: result channel with hit flags, entry distances and visit order.
interface rbst_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit_first;
  logic                              hit_second;
  logic signed [rbst_pkg::VAL_W-1:0] entry_first;
  logic signed [rbst_pkg::VAL_W-1:0] entry_second;
  logic                              visit_second_first;

  modport source (output valid, hit_first, hit_second, entry_first, entry_second,
                  visit_second_first, input ready);
  modport sink   (input valid, hit_first, hit_second, entry_first, entry_second,
                  visit_second_first, output ready);
endinterface

// ===== hdl/ray_box_pair_slab_test_top.sv =====
// Top level: ray box-pair slab test with two child lanes and APB config.
//
//  channel | dir | handshake     | contents
//  in_if   | in  | valid/ready   | six bound pairs, t_limit
//  out_if  | out | valid/ready   | hits, entries, visit order
//  apb     | in  | psel/penable  | ray origin and direction registers
//
// One item per cycle sustained while the output is not stalled. Results pass
// through the restoring dividers that resolve one quotient bit per stage.
// Reset clears valid bits and config registers; no clearing pass.
// A stalled output blocks input only once a result reaches the last stage.
module ray_box_pair_slab_test_top #(
  parameter int COORD_WIDTH   = rbst_pkg::COORD_WIDTH,
  parameter int FRACTION_BITS = rbst_pkg::FRACTION_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rbst_in_if.sink                     in_if,
  rbst_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbst_pkg::APB_AW-1:0] paddr,
  input  logic [rbst_pkg::APB_DW-1:0] pwdata,
  output logic [rbst_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int CW = COORD_WIDTH;
  localparam int LD = COORD_WIDTH + 1 + FRACTION_BITS + 4;

  logic [rbst_pkg::APB_DW-1:0] regs_q [rbst_pkg::NUM_REGS];
  logic                        en;
  logic                        v_q   [LD];
  logic signed [CW-1:0]        lim_q [LD];
  logic signed [CW-1:0]        org   [3];
  logic signed [CW-1:0]        dir   [3];
  logic signed [CW-1:0]        lo0   [3];
  logic signed [CW-1:0]        hi0   [3];
  logic signed [CW-1:0]        lo1   [3];
  logic signed [CW-1:0]        hi1   [3];
  logic signed [CW-1:0]        entry0;
  logic signed [CW-1:0]        entry1;
  logic                        ok0;
  logic                        ok1;
  rbst_pkg::rbst_reg_e         reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = rbst_pkg::rbst_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rbst_pkg::NUM_REGS; i++) regs_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        rbst_pkg::REG_ORIGIN_X: regs_q[rbst_pkg::REG_ORIGIN_X] <= pwdata;
        rbst_pkg::REG_ORIGIN_Y: regs_q[rbst_pkg::REG_ORIGIN_Y] <= pwdata;
        rbst_pkg::REG_ORIGIN_Z: regs_q[rbst_pkg::REG_ORIGIN_Z] <= pwdata;
        rbst_pkg::REG_DIR_X:    regs_q[rbst_pkg::REG_DIR_X]    <= pwdata;
        rbst_pkg::REG_DIR_Y:    regs_q[rbst_pkg::REG_DIR_Y]    <= pwdata;
        rbst_pkg::REG_DIR_Z:    regs_q[rbst_pkg::REG_DIR_Z]    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rbst_pkg::REG_ORIGIN_X: prdata = regs_q[rbst_pkg::REG_ORIGIN_X];
      rbst_pkg::REG_ORIGIN_Y: prdata = regs_q[rbst_pkg::REG_ORIGIN_Y];
      rbst_pkg::REG_ORIGIN_Z: prdata = regs_q[rbst_pkg::REG_ORIGIN_Z];
      rbst_pkg::REG_DIR_X:    prdata = regs_q[rbst_pkg::REG_DIR_X];
      rbst_pkg::REG_DIR_Y:    prdata = regs_q[rbst_pkg::REG_DIR_Y];
      rbst_pkg::REG_DIR_Z:    prdata = regs_q[rbst_pkg::REG_DIR_Z];
      default:                prdata = '0;
    endcase
  end

  // unpack ray and bounds per lane
  always_comb begin
    org[0] = regs_q[rbst_pkg::REG_ORIGIN_X][CW-1:0];
    org[1] = regs_q[rbst_pkg::REG_ORIGIN_Y][CW-1:0];
    org[2] = regs_q[rbst_pkg::REG_ORIGIN_Z][CW-1:0];
    dir[0] = regs_q[rbst_pkg::REG_DIR_X][CW-1:0];
    dir[1] = regs_q[rbst_pkg::REG_DIR_Y][CW-1:0];
    dir[2] = regs_q[rbst_pkg::REG_DIR_Z][CW-1:0];
    lo0[0] = in_if.x_lo_pair[CW-1:0];    lo1[0] = in_if.x_lo_pair[2*CW-1:CW];
    hi0[0] = in_if.x_hi_pair[CW-1:0];    hi1[0] = in_if.x_hi_pair[2*CW-1:CW];
    lo0[1] = in_if.y_lo_pair[CW-1:0];    lo1[1] = in_if.y_lo_pair[2*CW-1:CW];
    hi0[1] = in_if.y_hi_pair[CW-1:0];    hi1[1] = in_if.y_hi_pair[2*CW-1:CW];
    lo0[2] = in_if.z_lo_pair[CW-1:0];    lo1[2] = in_if.z_lo_pair[2*CW-1:CW];
    hi0[2] = in_if.z_hi_pair[CW-1:0];    hi1[2] = in_if.z_hi_pair[2*CW-1:CW];
  end

  // valid bits and hit limit travel alongside the lanes
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LD; s++) v_q[s] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_if.valid;
      for (int s = 1; s < LD; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lim_q[0] <= in_if.t_limit[CW-1:0];
      for (int s = 1; s < LD; s++) lim_q[s] <= lim_q[s-1];
    end
  end

  rbst_lane #(.CW(CW), .FW(FRACTION_BITS)) u_lane0 (
    .clk_i (clk_i), .en_i (en), .org_i (org), .dir_i (dir),
    .lo_i (lo0), .hi_i (hi0), .entry_o (entry0), .ok_o (ok0)
  );

  rbst_lane #(.CW(CW), .FW(FRACTION_BITS)) u_lane1 (
    .clk_i (clk_i), .en_i (en), .org_i (org), .dir_i (dir),
    .lo_i (lo1), .hi_i (hi1), .entry_o (entry1), .ok_o (ok1)
  );

  rbst_merge #(.CW(CW)) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .last_v_i (v_q[LD-1]),
    .entry0_i (entry0),
    .ok0_i    (ok0),
    .entry1_i (entry1),
    .ok1_i    (ok1),
    .limit_i  (lim_q[LD-1]),
    .en_o     (en),
    .out_if   (out_if)
  );

endmodule

// ===== hdl/rbst_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module rbst_div #(
  parameter int CW = rbst_pkg::COORD_WIDTH,
  parameter int FW = rbst_pkg::FRACTION_BITS
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW:0]   num_i,
  input  logic signed [CW-1:0] dir_i,
  output logic signed [CW-1:0] quot_o
);

  localparam int QW = CW + 1 + FW;
  localparam logic [QW-1:0] MAXP = QW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [QW-1:0] MINB = QW'(64'd1 << (CW - 1));
  localparam logic [CW-1:0] MAXN = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0] ud;
  logic [CW:0]   un;
  logic [QW-1:0] a_q   [QW+1];
  logic [CW-2:0] rem_q [QW];
  logic          ns_q  [QW+1];
  logic [QW-1:0] qneg;
  logic [CW-1:0] sat;

  // magnitudes; divisor must stay static while items flow (not enforced here)
  assign ud = dir_i[CW-1] ? (~dir_i + 1'b1) : dir_i;
  assign un = num_i[CW] ? (~num_i + 1'b1) : num_i;

  // entry stage: dividend aligned by the fraction bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]   <= {un, {FW{1'b0}}};
      rem_q[0] <= '0;
      ns_q[0]  <= num_i[CW];
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [CW-1:0] t;
    logic [CW-1:0] diff;
    logic          ge;
    if (k == 0) begin : g_first
      assign t = {rem_q[k], a_q[k][QW-1]};
    end else begin : g_rest
      assign t = {rem_q[k], a_q[k][QW-1]};
    end
    assign ge   = (t >= ud);
    assign diff = t - ud;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k+1]  <= {a_q[k][QW-2:0], ge};
        ns_q[k+1] <= ns_q[k];
      end
    end
    if (k + 1 < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff[CW-2:0] : t[CW-2:0];
        end
      end
    end
  end

  // sign and saturation
  assign qneg = ~a_q[QW] + 1'b1;
  always_comb begin
    if (dir_i == '0) begin
      sat = ns_q[QW] ? MINN : MAXN;
    end else if (ns_q[QW] ^ dir_i[CW-1]) begin
      sat = (a_q[QW] > MINB) ? MINN : qneg[CW-1:0];
    end else begin
      sat = (a_q[QW] > MAXP) ? MAXN : a_q[QW][CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_o <= sat;
    end
  end

endmodule

// ===== hdl/rbst_lane.sv =====
// One child lane: six slab divisions, per-axis ordering, entry/exit combine.
module rbst_lane #(
  parameter int CW = rbst_pkg::COORD_WIDTH,
  parameter int FW = rbst_pkg::FRACTION_BITS
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] org_i [3],
  input  logic signed [CW-1:0] dir_i [3],
  input  logic signed [CW-1:0] lo_i  [3],
  input  logic signed [CW-1:0] hi_i  [3],
  output logic signed [CW-1:0] entry_o,
  output logic                 ok_o
);

  logic signed [CW-1:0] t0   [3];
  logic signed [CW-1:0] t1   [3];
  logic signed [CW-1:0] tl_q [3];
  logic signed [CW-1:0] th_q [3];
  logic signed [CW-1:0] tin;
  logic signed [CW-1:0] tout;
  logic signed [CW-1:0] tin_pos;

  // slab distances per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [CW:0] num_lo;
    logic signed [CW:0] num_hi;
    assign num_lo = {lo_i[a][CW-1], lo_i[a]} - {org_i[a][CW-1], org_i[a]};
    assign num_hi = {hi_i[a][CW-1], hi_i[a]} - {org_i[a][CW-1], org_i[a]};

    rbst_div #(.CW(CW), .FW(FW)) u_div_lo (
      .clk_i (clk_i), .en_i (en_i), .num_i (num_lo), .dir_i (dir_i[a]), .quot_o (t0[a])
    );
    rbst_div #(.CW(CW), .FW(FW)) u_div_hi (
      .clk_i (clk_i), .en_i (en_i), .num_i (num_hi), .dir_i (dir_i[a]), .quot_o (t1[a])
    );

    // order the slab pair
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tl_q[a] <= (t0[a] < t1[a]) ? t0[a] : t1[a];
        th_q[a] <= (t0[a] < t1[a]) ? t1[a] : t0[a];
      end
    end
  end

  // largest low, smallest high
  always_comb begin
    tin  = tl_q[0];
    tout = th_q[0];
    for (int a = 1; a < 3; a++) begin
      if (tl_q[a] > tin)  tin  = tl_q[a];
      if (th_q[a] < tout) tout = th_q[a];
    end
    tin_pos = (tin > 0) ? tin : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_o <= tin;
      ok_o    <= (tout >= tin_pos);
    end
  end

endmodule

// ===== hdl/rbst_merge.sv =====
// Merge stage: limit check, visit order and the output register.
module rbst_merge #(
  parameter int CW = rbst_pkg::COORD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 last_v_i,
  input  logic signed [CW-1:0] entry0_i,
  input  logic                 ok0_i,
  input  logic signed [CW-1:0] entry1_i,
  input  logic                 ok1_i,
  input  logic signed [CW-1:0] limit_i,
  output logic                 en_o,
  rbst_out_if.source           out_if
);

  logic out_v_q;
  logic load;
  logic h0;
  logic h1;

  // output register takes a new result when empty or being taken
  assign load = !out_v_q || out_if.ready;
  assign en_o = load || !last_v_i;

  assign h0 = ok0_i && (entry0_i < limit_i);
  assign h1 = ok1_i && (entry1_i < limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load) begin
      out_v_q <= last_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && last_v_i) begin
      out_if.hit_first          <= h0;
      out_if.hit_second         <= h1;
      out_if.entry_first        <= rbst_pkg::VAL_W'(entry0_i);
      out_if.entry_second       <= rbst_pkg::VAL_W'(entry1_i);
      out_if.visit_second_first <= h1 && (!h0 || !(entry0_i < entry1_i));
    end
  end

  assign out_if.valid = out_v_q;

endmodule

// ===== hdl/rbst_checker.sv =====
// Checker on the top-level ports, bound to the top level.
module rbst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic hit_second_i,
  input logic visit_i,
  input logic [rbst_pkg::VAL_W-1:0] entry_first_i
);

  // a waiting result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a waiting result holds its first entry value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(entry_first_i))
    else $error("result changed while stalled");

  // input is open whenever the output register can move
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input blocked with output free");

  // second-first order needs a hit on the second child
  a_visit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && visit_i |-> hit_second_i)
    else $error("visit order without second hit");

endmodule

bind ray_box_pair_slab_test_top rbst_checker u_rbst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .hit_second_i  (out_if.hit_second),
  .visit_i       (out_if.visit_second_first),
  .entry_first_i (out_if.entry_first)
);
